// ----- src/mtc_pkg.sv -----
// ----------------------------------------------------------------------------
// mtc_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the missing-tooth crank decoder.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;

  // Field widths
  localparam int PERIOD_W   = 32;
  localparam int TEETH_W    = 8;
  localparam int MINP_W     = 16;
  localparam int RPM_W      = 15;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = PERIOD_W + TEETH_W;

  // Sync modes
  localparam logic [MODE_W-1:0] MODE_LOST    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SYNCING = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SYNCED  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TEETH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING_TEETH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD    = 2'd2;

  // Configuration reset values
  localparam logic [TEETH_W-1:0] TOTAL_TEETH_RST   = 8'd36;
  localparam logic [TEETH_W-1:0] MISSING_TEETH_RST = 8'd1;
  localparam logic [MINP_W-1:0]  MIN_PERIOD_RST    = 16'd50;

  // RPM arithmetic
  localparam int RPM_NUMERATOR = 60000000;
  localparam int RPM_LIMIT     = 20000;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic hist_upd;
    logic mean_zero;
    logic mean_start;
    logic mean_load;
    logic sync_upd;
    logic rpm_start;
    logic rpm_load;
    logic out_load;
  } mtc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic keep;
    logic cnt_zero;
    logic rpm_go;
    logic div_done;
    logic out_free;
  } mtc_sts_t;

endpackage

// ----- src/missing_tooth_crank_decoder.sv -----
// Flow: first and noise edges go from accept straight to the result; kept edges
//   also pass history update, sync update and up to both divisions (mean, rpm).
// Edges are taken one at a time; a stalled result holds the input off.
// Reset: synchronous active-low rst_n; no clearing pass, history valid bits
//   clear at once.
// ----------------------------------------------------------------------------
// missing_tooth_crank_decoder
// Decodes a missing-tooth trigger wheel from tooth edge timestamps: period,
// gap detection, sync tracking and held rpm estimate.
// ----------------------------------------------------------------------------
module missing_tooth_crank_decoder #(
  parameter int HISTORY_DEPTH = mtc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mtc_pkg::PERIOD_W-1:0]    in_edge_time_us,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic [mtc_pkg::PERIOD_W-1:0]    out_period_us,
  output logic                            out_is_gap,
  output logic [mtc_pkg::MODE_W-1:0]      out_sync_status,
  output logic [mtc_pkg::TEETH_W-1:0]     out_tooth_position,
  output logic [mtc_pkg::RPM_W-1:0]       out_engine_rpm
);

  mtc_pkg::mtc_cmd_t cmd;
  mtc_pkg::mtc_sts_t sts;

  // Register writes are always accepted
  assign cfg_ready = 1'b1;

  mtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mtc_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_edge_time_us    (in_edge_time_us),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_accepted       (out_accepted),
    .out_period_us      (out_period_us),
    .out_is_gap         (out_is_gap),
    .out_sync_status    (out_sync_status),
    .out_tooth_position (out_tooth_position),
    .out_engine_rpm     (out_engine_rpm)
  );

endmodule

// ----- src/mtc_div.sv -----
// ----------------------------------------------------------------------------
// mtc_div
// Restoring divider, one quotient bit per cycle. done rises once all NUM_W
// quotient bits are in and holds until the next start.
// ----------------------------------------------------------------------------
module mtc_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   diff;
  logic             ge;

  // One restoring step: shift in next numerator bit, subtract if it fits
  assign sh   = {rem_r, quo_r[NUM_W-1]};
  assign diff = sh - {1'b0, den_r};
  assign ge   = (sh >= {1'b0, den_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      rem_nxt = ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// ----- src/mtc_ctrl.sv -----
// ----------------------------------------------------------------------------
// mtc_ctrl
// Sequencer for one edge transaction: capture, history update, mean
// division, sync update, rpm division and result hand-off.
// ----------------------------------------------------------------------------
module mtc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mtc_pkg::mtc_sts_t sts,
  output mtc_pkg::mtc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HIST   = 3'd1;
  localparam logic [2:0] S_MSTART = 3'd2;
  localparam logic [2:0] S_MWAIT  = 3'd3;
  localparam logic [2:0] S_SYNC   = 3'd4;
  localparam logic [2:0] S_RWAIT  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = sts.keep ? S_HIST : S_FINISH;
        end
      end
      S_HIST: begin
        cmd.hist_upd = 1'b1;
        state_nxt    = S_MSTART;
      end
      S_MSTART: begin
        if (sts.cnt_zero) begin
          cmd.mean_zero = 1'b1;
          state_nxt     = S_SYNC;
        end else begin
          cmd.mean_start = 1'b1;
          state_nxt      = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (sts.div_done) begin
          cmd.mean_load = 1'b1;
          state_nxt     = S_SYNC;
        end
      end
      S_SYNC: begin
        cmd.sync_upd = 1'b1;
        if (sts.rpm_go) begin
          cmd.rpm_start = 1'b1;
          state_nxt     = S_RWAIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_RWAIT: begin
        if (sts.div_done) begin
          cmd.rpm_load = 1'b1;
          state_nxt    = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- src/mtc_dp.sv -----
// ----------------------------------------------------------------------------
// mtc_dp
// Datapath: configuration registers, edge capture, period history with
// running sum and nonzero count, shared divider, sync tracking, rpm hold
// and the output register.
// ----------------------------------------------------------------------------
module mtc_dp #(
  parameter int HISTORY_DEPTH = mtc_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [mtc_pkg::PERIOD_W-1:0]    in_edge_time_us,
  input  mtc_pkg::mtc_cmd_t               cmd,
  output mtc_pkg::mtc_sts_t               sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_accepted,
  output logic [mtc_pkg::PERIOD_W-1:0]    out_period_us,
  output logic                            out_is_gap,
  output logic [mtc_pkg::MODE_W-1:0]      out_sync_status,
  output logic [mtc_pkg::TEETH_W-1:0]     out_tooth_position,
  output logic [mtc_pkg::RPM_W-1:0]       out_engine_rpm
);

  localparam int PW     = mtc_pkg::PERIOD_W;
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = PW + SLOT_W;
  localparam int NUM_W  = SUM_W;
  localparam int DEN_W  = mtc_pkg::PROD_W;

  // Configuration registers
  logic [mtc_pkg::TEETH_W-1:0] total_r, missing_r;
  logic [mtc_pkg::MINP_W-1:0]  minp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= mtc_pkg::TOTAL_TEETH_RST;
      missing_r <= mtc_pkg::MISSING_TEETH_RST;
      minp_r    <= mtc_pkg::MIN_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mtc_pkg::REG_TOTAL_TEETH:   total_r   <= cfg_data[mtc_pkg::TEETH_W-1:0];
        mtc_pkg::REG_MISSING_TEETH: missing_r <= cfg_data[mtc_pkg::TEETH_W-1:0];
        mtc_pkg::REG_MIN_PERIOD:    minp_r    <= cfg_data[mtc_pkg::MINP_W-1:0];
        default: ;
      endcase
    end
  end

  // Edge capture
  logic          have_r;
  logic [PW-1:0] last_r;
  logic [PW-1:0] period_r;
  logic          acc_r;
  logic [PW-1:0] diff;

  assign diff     = in_edge_time_us - last_r;
  assign sts.keep = have_r && (diff >= PW'(minp_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      last_r <= '0;
    end else if (cmd.capture) begin
      have_r <= 1'b1;
      last_r <= in_edge_time_us;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      period_r <= have_r ? diff : '0;
      acc_r    <= sts.keep;
    end
  end

  // Period history: memory plus per-entry valid bits, running sum and count
  logic [PW-1:0]            hist_mem [HISTORY_DEPTH];
  logic [PW-1:0]            rd_r;
  logic [HISTORY_DEPTH-1:0] vld_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [SUM_W-1:0]         sum_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [DEN_W-1:0]         prod_r;
  logic [PW-1:0]            old_val;

  assign old_val      = vld_r[slot_r] ? rd_r : '0;
  assign sts.cnt_zero = (cnt_r == '0);

  always_ff @(posedge clk) begin
    rd_r <= hist_mem[slot_r];
    if (cmd.hist_upd) begin
      hist_mem[slot_r] <= period_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      slot_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else if (cmd.hist_upd) begin
      vld_r[slot_r] <= 1'b1;
      slot_r <= (slot_r == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + SLOT_W'(1);
      sum_r  <= sum_r - SUM_W'(old_val) + SUM_W'(period_r);
      cnt_r  <= cnt_r - CNT_W'(old_val != '0) + CNT_W'(period_r != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_upd) begin
      prod_r <= DEN_W'(period_r) * DEN_W'(total_r);
    end
  end

  // Shared divider: history mean, then rpm
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quo;
  logic             div_start;

  assign div_start = cmd.mean_start || cmd.rpm_start;
  assign div_num   = cmd.mean_start ? sum_r : NUM_W'(mtc_pkg::RPM_NUMERATOR);
  assign div_den   = cmd.mean_start ? DEN_W'(cnt_r) : prod_r;

  mtc_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (sts.div_done)
  );

  logic [PW-1:0] mean_r;

  always_ff @(posedge clk) begin
    if (cmd.mean_zero) begin
      mean_r <= '0;
    end else if (cmd.mean_load) begin
      mean_r <= div_quo[PW-1:0];
    end
  end

  // Gap test and sync tracking
  logic [PW+1:0]               thr;
  logic                        gap_c;
  logic [mtc_pkg::TEETH_W-1:0] expected;
  logic [mtc_pkg::TEETH_W-1:0] teeth_inc;
  logic [mtc_pkg::MODE_W-1:0]  mode_r, mode_c;
  logic [mtc_pkg::TEETH_W-1:0] teeth_r, teeth_c;
  logic                        rpm_clr_c;
  logic [mtc_pkg::RPM_W-1:0]   rpm_r;
  logic                        gap_r;

  assign thr       = (PW+2)'(mean_r) + (PW+2)'(mean_r[PW-1:1]);
  assign gap_c     = (mean_r != '0) && ((PW+2)'(period_r) > thr);
  assign expected  = total_r - missing_r;
  assign teeth_inc = teeth_r + 8'd1;

  always_comb begin
    mode_c    = mode_r;
    teeth_c   = teeth_r;
    rpm_clr_c = 1'b0;
    case (mode_r)
      mtc_pkg::MODE_SYNCING: begin
        teeth_c = teeth_inc;
        if (gap_c) begin
          if (teeth_inc == expected) begin
            mode_c = mtc_pkg::MODE_SYNCED;
          end
          teeth_c = '0;
        end
      end
      mtc_pkg::MODE_SYNCED: begin
        teeth_c = teeth_inc;
        if (gap_c) begin
          if (teeth_inc != expected) begin
            mode_c    = mtc_pkg::MODE_LOST;
            rpm_clr_c = 1'b1;
          end
          teeth_c = '0;
        end
      end
      default: begin
        // lost, and the unused code acts as lost
        mode_c = gap_c ? mtc_pkg::MODE_SYNCING : mtc_pkg::MODE_LOST;
        if (gap_c) begin
          teeth_c = '0;
        end
      end
    endcase
  end

  assign sts.rpm_go = (mode_c != mtc_pkg::MODE_LOST) && (prod_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= mtc_pkg::MODE_LOST;
      teeth_r <= '0;
      rpm_r   <= '0;
    end else if (cmd.sync_upd) begin
      mode_r  <= mode_c;
      teeth_r <= teeth_c;
      if (rpm_clr_c) begin
        rpm_r <= '0;
      end
    end else if (cmd.rpm_load && (div_quo < NUM_W'(mtc_pkg::RPM_LIMIT))) begin
      rpm_r <= div_quo[mtc_pkg::RPM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      gap_r <= 1'b0;
    end else if (cmd.sync_upd) begin
      gap_r <= gap_c;
    end
  end

  // Output register
  logic out_valid_r, out_valid_nxt;

  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accepted       <= acc_r;
      out_period_us      <= period_r;
      out_is_gap         <= gap_r;
      out_sync_status    <= mode_r;
      out_tooth_position <= teeth_r;
      out_engine_rpm     <= rpm_r;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_div_not_instant: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !sts.div_done)
    else $error("divider reported done right after start");

  a_empty_history_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (sum_r == '0))
    else $error("history sum nonzero with no nonzero entries");

  a_lost_rpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == mtc_pkg::MODE_LOST) |-> (rpm_r == '0))
    else $error("rpm estimate nonzero while sync lost");

endmodule
